// File: rtl/first_fit_block_allocator_defines.svh
// Assertion helpers for the block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: rtl/ffa_pkg.sv
package ffa_pkg;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int SUCC_W = IDX_W + 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int HEADER_BYTES = 24;
  localparam int POOL_LIMIT_BYTES = 65536;
  localparam int ADDR_W = 16;
  localparam int POOL_W = 17;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic              free;
    logic [SUCC_W-1:0] succ;
  } desc_t;
endpackage

// File: rtl/first_fit_block_allocator.sv
// A request reads the head descriptor and walks the list to a hit or its end; an allocate
// that splits goes on through S_POP and S_SPLIT, a free goes on to a merge walk over the list.
// Throughput: one request at a time (in_stall is high outside idle), set by the walk
// over the descriptor memory with its single read port. A zero-byte allocate skips the walk.
// Reset (rst, synchronous): the pool is one free block of 65536 bytes with 63 spare
// descriptors; a pool size write re-initializes the same way. No clearing pass is needed.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] request_size,
  input  logic [15:0] block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] payload_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] pool_bytes_in_use
);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_POP, S_SPLIT, S_MSTART, S_MCUR, S_MNX, S_FINISH
  } state_t;

  localparam int IW = ffa_pkg::IDX_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int AW = ffa_pkg::ADDR_W;
  localparam int PW = ffa_pkg::POOL_W;
  localparam logic [PW-1:0] HDR = PW'(ffa_pkg::HEADER_BYTES);
  localparam logic [PW-1:0] POOL_MAX = PW'(ffa_pkg::POOL_LIMIT_BYTES);
  localparam logic [CW-1:0] SPARE_ALL = CW'(ffa_pkg::MAX_BLOCKS - 1);
  localparam logic [ffa_pkg::SUCC_W-1:0] END_MARK = ffa_pkg::SUCC_W'(ffa_pkg::MAX_BLOCKS);

  // Descriptor memory: one record per block, one read and one write port.
  ffa_pkg::desc_t desc_mem [ffa_pkg::MAX_BLOCKS];
  // Spare descriptor stack memory.
  logic [IW-1:0] stk_mem [ffa_pkg::MAX_BLOCKS];

  state_t state, state_next;
  logic op;
  logic [15:0] req, addr;
  logic [IW-1:0] cur, cur_next, nx_idx, nx_idx_next;
  ffa_pkg::desc_t cur_rec, cur_rec_next;
  logic [1:0] res_status, res_status_next;
  logic [AW-1:0] res_off, res_off_next;
  logic [CW-1:0] count, count_next, wmark, wmark_next;
  logic head_valid;
  logic [AW-1:0] pool_len;

  // Memory ports
  logic rd_en, wr_en, stk_rd_en, stk_wr_en;
  logic [IW-1:0] rd_addr, wr_addr, stk_rd_pos, stk_wr_pos, stk_wr_data;
  ffa_pkg::desc_t wr_data, rd_q, rd_rec, merged;
  logic rd_init_q;
  logic [IW-1:0] stk_q, stk_pos_q, stk_n;
  logic stk_orig_q;

  logic [PW-1:0] need, pool_sat, new_len, new_start, off_hit;
  logic hit;

  assign in_stall = (state != S_IDLE);
  // Hold a pool size write while a request is offered, so the two never meet.
  assign cfg_ready = (state == S_IDLE) && !in_valid;

  // Clamp the pool size into the legal range.
  always_comb begin
    pool_sat = pool_bytes_in_use;
    if (pool_sat > POOL_MAX) begin
      pool_sat = POOL_MAX;
    end
    if (pool_sat < HDR) begin
      pool_sat = HDR;
    end
  end

  // Head descriptor reads as its initial record until first written.
  always_comb begin
    if (rd_init_q) begin
      rd_rec.start = '0;
      rd_rec.len = pool_len;
      rd_rec.free = 1'b1;
      rd_rec.succ = END_MARK;
    end else begin
      rd_rec = rd_q;
    end
  end

  // Stack positions below the low-water mark still hold the initial descending order.
  assign stk_n = stk_orig_q ? (IW'(ffa_pkg::MAX_BLOCKS - 1) - stk_pos_q) : stk_q;

  assign need = {1'b0, req} + HDR;
  assign new_len = {1'b0, cur_rec.len} - need;
  assign new_start = {1'b0, cur_rec.start} + HDR + new_len;
  assign off_hit = {1'b0, rd_rec.start} + HDR;
  assign hit = (op == ffa_pkg::OP_ALLOC)
             ? (rd_rec.free && ({1'b0, rd_rec.len} >= need))
             : (off_hit == {1'b0, addr});

  always_comb begin
    merged = cur_rec;
    merged.len = AW'({1'b0, cur_rec.len} + {1'b0, rd_rec.len} + HDR);
    merged.succ = rd_rec.succ;
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    nx_idx_next = nx_idx;
    cur_rec_next = cur_rec;
    res_status_next = res_status;
    res_off_next = res_off;
    count_next = count;
    wmark_next = wmark;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = cur;
    wr_data = cur_rec;
    stk_rd_en = 1'b0;
    stk_rd_pos = IW'(count - CW'(1));
    stk_wr_en = 1'b0;
    stk_wr_pos = count[IW-1:0];
    stk_wr_data = nx_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ffa_pkg::ST_DONE;
          res_off_next = '0;
          cur_next = '0;
          if (operation == ffa_pkg::OP_ALLOC && request_size == '0) begin
            res_status_next = ffa_pkg::ST_NO_FIT;
            state_next = S_FINISH;
          end else begin
            rd_en = 1'b1;
            rd_addr = '0;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        cur_rec_next = rd_rec;
        if (hit) begin
          if (op == ffa_pkg::OP_FREE) begin
            // Mark free, then merge over the whole list.
            wr_en = 1'b1;
            wr_data = rd_rec;
            wr_data.free = 1'b1;
            state_next = S_MSTART;
          end else if ({1'b0, rd_rec.len} == need) begin
            wr_en = 1'b1;
            wr_data = rd_rec;
            wr_data.free = 1'b0;
            res_off_next = off_hit[AW-1:0];
            state_next = S_FINISH;
          end else if (count == '0) begin
            res_status_next = ffa_pkg::ST_NO_FIT;
            state_next = S_FINISH;
          end else begin
            stk_rd_en = 1'b1;
            state_next = S_POP;
          end
        end else if (rd_rec.succ[IW]) begin
          res_status_next = (op == ffa_pkg::OP_ALLOC) ? ffa_pkg::ST_NO_FIT
                                                      : ffa_pkg::ST_NOT_FOUND;
          state_next = S_FINISH;
        end else begin
          cur_next = rd_rec.succ[IW-1:0];
          rd_en = 1'b1;
          rd_addr = rd_rec.succ[IW-1:0];
        end
      end
      S_POP: begin
        if (stk_n == '0) begin
          res_status_next = ffa_pkg::ST_NO_FIT;
          state_next = S_FINISH;
        end else begin
          // Shrink the free block and link the new one after it.
          count_next = count - CW'(1);
          wmark_next = (count - CW'(1) < wmark) ? count - CW'(1) : wmark;
          nx_idx_next = stk_n;
          wr_en = 1'b1;
          wr_data = cur_rec;
          wr_data.len = new_len[AW-1:0];
          wr_data.succ = {1'b0, stk_n};
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        wr_en = 1'b1;
        wr_addr = nx_idx;
        wr_data.start = new_start[AW-1:0];
        wr_data.len = req;
        wr_data.free = 1'b0;
        wr_data.succ = cur_rec.succ;
        res_off_next = AW'(new_start + HDR);
        state_next = S_FINISH;
      end
      S_MSTART: begin
        rd_en = 1'b1;
        rd_addr = '0;
        cur_next = '0;
        state_next = S_MCUR;
      end
      S_MCUR: begin
        cur_rec_next = rd_rec;
        if (rd_rec.succ[IW]) begin
          state_next = S_FINISH;
        end else if (rd_rec.free) begin
          nx_idx_next = rd_rec.succ[IW-1:0];
          rd_en = 1'b1;
          rd_addr = rd_rec.succ[IW-1:0];
          state_next = S_MNX;
        end else begin
          cur_next = rd_rec.succ[IW-1:0];
          rd_en = 1'b1;
          rd_addr = rd_rec.succ[IW-1:0];
        end
      end
      S_MNX: begin
        if (rd_rec.free) begin
          // Absorb the neighbor and return its descriptor.
          cur_rec_next = merged;
          wr_en = 1'b1;
          wr_data = merged;
          stk_wr_en = 1'b1;
          count_next = count + CW'(1);
          if (rd_rec.succ[IW]) begin
            state_next = S_FINISH;
          end else begin
            nx_idx_next = rd_rec.succ[IW-1:0];
            rd_en = 1'b1;
            rd_addr = rd_rec.succ[IW-1:0];
          end
        end else if (rd_rec.succ[IW]) begin
          state_next = S_FINISH;
        end else begin
          cur_next = rd_rec.succ[IW-1:0];
          rd_en = 1'b1;
          rd_addr = rd_rec.succ[IW-1:0];
          state_next = S_MCUR;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      desc_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= desc_mem[rd_addr];
      rd_init_q <= (rd_addr == '0) && !head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[stk_wr_pos] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stk_q <= stk_mem[stk_rd_pos];
      stk_pos_q <= stk_rd_pos;
      stk_orig_q <= ({1'b0, stk_rd_pos} < wmark);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      count <= SPARE_ALL;
      wmark <= SPARE_ALL;
      head_valid <= 1'b0;
      pool_len <= AW'(POOL_MAX - HDR);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        // Re-initialize the pool as one free block.
        count <= SPARE_ALL;
        wmark <= SPARE_ALL;
        head_valid <= 1'b0;
        pool_len <= AW'(pool_sat - HDR);
      end else begin
        count <= count_next;
        wmark <= wmark_next;
        if (wr_en && wr_addr == '0) begin
          head_valid <= 1'b1;
        end
      end
      if (state == S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (state == S_IDLE && in_valid) begin
      op <= operation;
      req <= request_size;
      addr <= block_address;
    end
    cur <= cur_next;
    nx_idx <= nx_idx_next;
    cur_rec <= cur_rec_next;
    res_status <= res_status_next;
    res_off <= res_off_next;
    if (state == S_FINISH && (!out_valid || !out_stall)) begin
      status <= res_status;
      payload_offset <= res_off;
    end
  end

  `FFA_ASSERT_NOW(a_count_range, 1'b1, count <= SPARE_ALL)
  `FFA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state != S_IDLE)
  `FFA_ASSERT_NOW(a_pop_has_spare, state == S_POP, count != '0)

endmodule

// File: bench/first_fit_block_allocator_test.sv
module first_fit_block_allocator_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3 * ffa_pkg::MAX_BLOCKS + 20;
  localparam int RANDOM_REQUESTS = 1600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = ffa_pkg::OP_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] block_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] payload_offset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] pool_bytes_in_use = 17'd65536;

  always #2 clk = ~clk;

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .request_size(request_size), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .payload_offset(payload_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .pool_bytes_in_use(pool_bytes_in_use)
  );

  // Shadow copy of the allocator: descriptor list, spare stack, pool size.
  logic [31:0] blk_start [ffa_pkg::MAX_BLOCKS];
  logic [31:0] blk_len [ffa_pkg::MAX_BLOCKS];
  logic        blk_free [ffa_pkg::MAX_BLOCKS];
  logic [31:0] blk_next [ffa_pkg::MAX_BLOCKS];
  logic [31:0] spare_stack [ffa_pkg::MAX_BLOCKS];
  int unsigned spare_count;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
  } grant_t;

  grant_t expected_grants[$];
  // Offsets handed out and still live, so frees mostly hit real blocks.
  logic [15:0] live_offsets[$];

  int mismatches = 0;
  int grants_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;
  int no_fit_seen = 0;
  int not_found_seen = 0;
  bit hold_receiver = 1'b0;

  task automatic rebuild_pool(input logic [16:0] bytes);
    int unsigned b;
    b = bytes;
    if (b > ffa_pkg::POOL_LIMIT_BYTES) b = ffa_pkg::POOL_LIMIT_BYTES;
    if (b < ffa_pkg::HEADER_BYTES) b = ffa_pkg::HEADER_BYTES;
    for (int i = 0; i < ffa_pkg::MAX_BLOCKS; i++) begin
      blk_start[i] = 0;
      blk_len[i] = 0;
      blk_free[i] = 1'b0;
      blk_next[i] = 0;
      spare_stack[i] = 0;
    end
    blk_len[0] = b - ffa_pkg::HEADER_BYTES;
    blk_free[0] = 1'b1;
    blk_next[0] = ffa_pkg::MAX_BLOCKS;
    for (int i = 1; i < ffa_pkg::MAX_BLOCKS; i++) spare_stack[i - 1] = ffa_pkg::MAX_BLOCKS - i;
    spare_count = ffa_pkg::MAX_BLOCKS - 1;
    live_offsets.delete();
  endtask

  function automatic void coalesce_free_runs();
    int unsigned cur;
    int unsigned nx;
    int unsigned steps;
    cur = 0;
    steps = 0;
    while (cur < ffa_pkg::MAX_BLOCKS && steps < 2 * ffa_pkg::MAX_BLOCKS) begin
      nx = blk_next[cur];
      steps++;
      if (blk_free[cur] && nx < ffa_pkg::MAX_BLOCKS && blk_free[nx]) begin
        blk_len[cur] += blk_len[nx] + ffa_pkg::HEADER_BYTES;
        blk_next[cur] = blk_next[nx];
        if (spare_count < ffa_pkg::MAX_BLOCKS) begin
          spare_stack[spare_count] = nx;
          spare_count++;
        end
      end else begin
        cur = nx;
      end
    end
  endfunction

  // Apply one request to the shadow list and return the grant it yields.
  function automatic grant_t predict_grant(input logic op, input logic [15:0] size,
                                           input logic [15:0] addr);
    grant_t g;
    int unsigned cur;
    int unsigned steps;
    int unsigned need;
    int unsigned n;
    g.status = ffa_pkg::ST_DONE;
    g.offset = '0;
    cur = 0;
    steps = 0;
    if (op == ffa_pkg::OP_ALLOC) begin
      need = size + ffa_pkg::HEADER_BYTES;
      if (size == 0) begin
        g.status = ffa_pkg::ST_NO_FIT;
      end else begin
        while (cur < ffa_pkg::MAX_BLOCKS && steps < ffa_pkg::MAX_BLOCKS) begin
          if (blk_free[cur] && blk_len[cur] >= need) break;
          cur = blk_next[cur];
          steps++;
        end
        if (cur >= ffa_pkg::MAX_BLOCKS || steps >= ffa_pkg::MAX_BLOCKS) begin
          g.status = ffa_pkg::ST_NO_FIT;
        end else if (blk_len[cur] == need) begin
          blk_free[cur] = 1'b0;
          g.offset = 16'(blk_start[cur] + ffa_pkg::HEADER_BYTES);
        end else if (spare_count == 0) begin
          g.status = ffa_pkg::ST_NO_FIT;
        end else begin
          n = spare_stack[spare_count - 1];
          if (n >= ffa_pkg::MAX_BLOCKS || n == 0) begin
            g.status = ffa_pkg::ST_NO_FIT;
          end else begin
            spare_count--;
            blk_len[cur] -= need;
            blk_start[n] = blk_start[cur] + ffa_pkg::HEADER_BYTES + blk_len[cur];
            blk_len[n] = size;
            blk_free[n] = 1'b0;
            blk_next[n] = blk_next[cur];
            blk_next[cur] = n;
            g.offset = 16'(blk_start[n] + ffa_pkg::HEADER_BYTES);
          end
        end
      end
    end else begin
      while (cur < ffa_pkg::MAX_BLOCKS && steps < ffa_pkg::MAX_BLOCKS) begin
        if (16'(blk_start[cur] + ffa_pkg::HEADER_BYTES) == addr &&
            (blk_start[cur] + ffa_pkg::HEADER_BYTES) < 32'h10000) break;
        cur = blk_next[cur];
        steps++;
      end
      if (cur >= ffa_pkg::MAX_BLOCKS || steps >= ffa_pkg::MAX_BLOCKS) begin
        g.status = ffa_pkg::ST_NOT_FOUND;
      end else begin
        blk_free[cur] = 1'b1;
        coalesce_free_runs();
      end
    end
    return g;
  endfunction

  // Directed table: op, size, address, and a typed-in grant where it is obvious.
  typedef struct {
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;
    bit          has_fixed;
    grant_t      fixed;
  } row_t;

  row_t directed_rows[$];

  function automatic row_t mk_row(input logic op, input int size, input int addr,
                                  input bit has_fixed, input logic [1:0] st,
                                  input int off);
    row_t r;
    r.op = op;
    r.size = 16'(size);
    r.addr = 16'(addr);
    r.has_fixed = has_fixed;
    r.fixed.status = st;
    r.fixed.offset = 16'(off);
    return r;
  endfunction

  // Issue one request: hold valid until the block takes it. Valid stays up
  // across back-to-back requests, so no lower-and-raise in one step.
  task automatic send_request(input logic op, input logic [15:0] size,
                              input logic [15:0] addr, input bit has_fixed,
                              input grant_t fixed);
    grant_t g;
    operation <= op;
    request_size <= size;
    block_address <= addr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = predict_grant(op, size, addr);
    if (has_fixed && g !== fixed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with prediction: op=%0d size=%0d typed %0d/%0d",
                 op, size, fixed.status, fixed.offset);
    end
    expected_grants.push_back(g);
    requests_sent++;
    if (op == ffa_pkg::OP_ALLOC && g.status == ffa_pkg::ST_DONE)
      live_offsets.push_back(g.offset);
    if (op == ffa_pkg::OP_FREE && g.status == ffa_pkg::ST_DONE)
      for (int i = 0; i < live_offsets.size(); i++)
        if (live_offsets[i] == addr) begin
          live_offsets.delete(i);
          break;
        end
  endtask

  task automatic sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    in_valid <= 1'b0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 40)) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [16:0] bytes);
    pool_bytes_in_use <= bytes;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rebuild_pool(bytes);
  endtask

  // One random request: mostly allocations with frees of live blocks, plus noise.
  task automatic random_request(input int max_size);
    int r;
    grant_t none;
    logic [15:0] a;
    none = '0;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_request(ffa_pkg::OP_ALLOC, 16'($urandom_range(1, max_size)), 16'($urandom),
                   1'b0, none);
    end else if (r < 85 && live_offsets.size() != 0) begin
      a = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
      send_request(ffa_pkg::OP_FREE, 16'($urandom), a, 1'b0, none);
    end else if (r < 92) begin
      send_request(ffa_pkg::OP_ALLOC, 16'($urandom), 16'($urandom), 1'b0, none);
    end else begin
      send_request(ffa_pkg::OP_FREE, 16'($urandom), 16'($urandom), 1'b0, none);
    end
  endtask

  // Check each grant against the oldest expectation.
  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst && out_valid && !out_stall) begin
      grants_seen++;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected grant: status=%0d offset=%0d", status, payload_offset);
      end else begin
        exp_g = expected_grants.pop_front();
        if (exp_g.status == ffa_pkg::ST_NO_FIT) no_fit_seen++;
        if (exp_g.status == ffa_pkg::ST_NOT_FOUND) not_found_seen++;
        if (status !== exp_g.status || payload_offset !== exp_g.offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("grant mismatch: expected status=%0d offset=%0d, got %0d/%0d",
                     exp_g.status, exp_g.offset, status, payload_offset);
        end
      end
    end
  end

  // Receiver stall: mostly low, often high at random, sometimes toggled, and held high on demand.
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) out_stall <= 1'b0;
      else if (r < 98) out_stall <= 1'b1;
      else out_stall <= ~out_stall;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  task automatic hold_off_receiver();
    hold_receiver = 1'b1;
    repeat (600) @(posedge clk);
    hold_receiver = 1'b0;
  endtask

  // Watchdog: count cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d grants pending", expected_grants.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    grant_t none;
    int rounds;
    none = '0;
    rebuild_pool(17'd65536);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset: zero-byte allocate, first allocations cut from the pool tail.
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 0, 0, 1'b1, ffa_pkg::ST_NO_FIT, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 16, 0, 1'b1, ffa_pkg::ST_DONE,
                                   65536 - 16));
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 65535, 0, 1'b1, ffa_pkg::ST_NO_FIT, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 65535, 1'b1, ffa_pkg::ST_NOT_FOUND, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 0, 1'b1, ffa_pkg::ST_NOT_FOUND, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 65536 - 16, 1'b1, ffa_pkg::ST_DONE, 0));
    // Free again: the block has merged into the head, so the address is gone.
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 65536 - 16, 1'b0, ffa_pkg::ST_DONE, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 24, 1'b1, ffa_pkg::ST_DONE, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 100, 0, 1'b0, ffa_pkg::ST_DONE, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 200, 0, 1'b0, ffa_pkg::ST_DONE, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 300, 0, 1'b0, ffa_pkg::ST_DONE, 0));
    // Free the middle then the neighbors: merges on both sides.
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 65536 - 100 - 24 - 200, 1'b0,
                                   ffa_pkg::ST_DONE, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 65536 - 100, 1'b0,
                                   ffa_pkg::ST_DONE, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 65536 - 100 - 24 - 200 - 24 - 300,
                                   1'b0, ffa_pkg::ST_DONE, 0));
    // Whole first block minus nothing: exact fit of the pool.
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 65536 - 48, 0, 1'b1, ffa_pkg::ST_DONE, 24));
    directed_rows.push_back(mk_row(ffa_pkg::OP_ALLOC, 1, 0, 1'b1, ffa_pkg::ST_NO_FIT, 0));
    directed_rows.push_back(mk_row(ffa_pkg::OP_FREE, 0, 24, 1'b1, ffa_pkg::ST_DONE, 0));

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
                   directed_rows[i].has_fixed, directed_rows[i].fixed);
      sender_gap();
    end
    wait_drained();

    // Small pools: no room at all, then run out of descriptors.
    write_pool_size(17'd24);
    send_request(ffa_pkg::OP_ALLOC, 16'd1, 16'd0, 1'b1,
                 '{status: ffa_pkg::ST_NO_FIT, offset: 16'd0});
    wait_drained();
    write_pool_size(17'd2000);
    for (int i = 0; i < 70; i++) begin
      send_request(ffa_pkg::OP_ALLOC, 16'($urandom_range(1, 4)), 16'd0, 1'b0, none);
      sender_gap();
    end
    for (int i = 0; i < 8; i++) random_request(40);
    // Pause until every grant is back.
    wait_drained();

    // Long receiver hold while requests keep coming, so the block backs up.
    write_pool_size(17'h1FFFF);
    fork
      hold_off_receiver();
      for (int i = 0; i < 40; i++) random_request(2000);
    join
    wait_drained();

    // Random phases over several pool sizes, sizes mostly small.
    rounds = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      case (rounds % 4)
        0: write_pool_size(17'd65536);
        1: write_pool_size(17'($urandom_range(24, 4000)));
        2: write_pool_size(17'($urandom_range(0, 23)));
        default: write_pool_size(17'($urandom_range(20000, 131071)));
      endcase
      for (int i = 0; i < 250; i++) begin
        random_request((i % 50 == 0) ? 65535 : 600);
        sender_gap();
      end
      wait_drained();
      rounds++;
    end

    $display("requests=%0d grants=%0d no_fit=%0d not_found=%0d pool phases=%0d",
             requests_sent, grants_seen, no_fit_seen, not_found_seen, rounds + 4);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("mismatches=%0d left over=%0d", mismatches, expected_grants.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
